// ===== rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and types for the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned BaseBits = 63;
  localparam int unsigned ExpFieldBits = 63;
  localparam int unsigned ValueBits = 30;
  localparam int unsigned ExpBitsDefault = 63;

  localparam logic [63:0] PrimeWide = 64'd1000000007;
  localparam logic [ValueBits-1:0] PrimeMod = PrimeWide[ValueBits-1:0];
  localparam logic [31:0] PrimeTwice = 32'(PrimeWide * 64'd2);
  // Barrett constant floor(2^60 / p)
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / PrimeWide);
  // 2^30 mod p, folds the upper base bits back in
  localparam logic [ValueBits-1:0] Fold30 = 30'((64'd1 << 30) % PrimeWide);
  localparam logic [31:0] HiScale = 32'd1 << 30;
  // Fermat inverse exponent p - 2
  localparam logic [ValueBits-1:0] InvExp = 30'(PrimeWide - 64'd2);

  localparam logic OpPow = 1'b0;
  localparam logic OpInv = 1'b1;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_QUOT,
    MM_SUB,
    MM_FIX
  } mm_phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HI,
    S_WAIT,
    S_STEP,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    K_HI,
    K_BASE,
    K_ACC,
    K_SQ
  } mm_kind_e;

  typedef struct packed {
    logic                 start;
    logic [31:0]          a;
    logic [31:0]          b;
    logic [ValueBits-1:0] c;
  } mm_req_t;

  typedef struct packed {
    logic                 done;
    logic [ValueBits-1:0] value;
  } mm_rsp_t;

  typedef struct packed {
    logic                 valid;
    logic [ValueBits-1:0] value;
  } res_t;

endpackage

// ===== rtl/modexp_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mulmod
// Computes (a * b + c) mod p on one shared 32x32 multiplier with Barrett
// reduction: product, quotient estimate, q * p subtract, final correction.
// ----------------------------------------------------------------------------
module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  mm_phase_e            phase_q, phase_d;
  logic [59:0]          x_q, x_d;
  logic [30:0]          q_q, q_d;
  logic [31:0]          r_q, r_d;
  logic [ValueBits-1:0] res_q, res_d;
  logic                 done_q, done_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] sum;

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign sum   = mul_p + 64'(req_i.c);

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    q_d     = q_q;
    r_d     = r_q;
    res_d   = res_q;
    done_d  = 1'b0;
    mul_a   = req_i.a;
    mul_b   = req_i.b;
    case (phase_q)
      MM_IDLE: begin
        if (req_i.start) begin
          x_d     = sum[59:0];
          phase_d = MM_QUOT;
        end
      end
      MM_QUOT: begin
        mul_a   = {1'b0, x_q[59:29]};
        mul_b   = {1'b0, BarrettMu};
        q_d     = mul_p[61:31];
        phase_d = MM_SUB;
      end
      MM_SUB: begin
        mul_a   = {1'b0, q_q};
        mul_b   = {2'b0, PrimeMod};
        r_d     = x_q[31:0] - mul_p[31:0];
        phase_d = MM_FIX;
      end
      MM_FIX: begin
        if (r_q >= PrimeTwice) begin
          res_d = 30'(r_q - PrimeTwice);
        end else if (r_q >= {2'b0, PrimeMod}) begin
          res_d = 30'(r_q - {2'b0, PrimeMod});
        end else begin
          res_d = r_q[ValueBits-1:0];
        end
        done_d  = 1'b1;
        phase_d = MM_IDLE;
      end
      default: phase_d = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    q_q   <= q_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule

// ===== rtl/modexp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_seq
// Square-and-multiply sequencer: reduces the base, then walks the exponent
// LSB first, issuing multiply and square requests to the shared unit.
// ----------------------------------------------------------------------------
module modexp_seq
  import modexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = ExpBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [BaseBits-1:0]     base_i,
  input  logic [ExpFieldBits-1:0] exponent_i,
  input  logic                    res_free_i,
  output res_t                    res_o,
  output mm_req_t                 req_o,
  input  mm_rsp_t                 rsp_i
);

  localparam int unsigned UseBits = (EXP_BITS < ExpFieldBits) ? EXP_BITS : ExpFieldBits;
  localparam int unsigned EW = (UseBits > ValueBits) ? UseBits : ValueBits;

  seq_state_e           state_q, state_d;
  mm_kind_e             kind_q, kind_d;
  logic [BaseBits-1:0]  base_q, base_d;
  logic [EW-1:0]        e_q, e_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic [ValueBits-1:0] sq_q, sq_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    base_d     = base_q;
    e_d        = e_q;
    acc_d      = acc_q;
    sq_d       = sq_q;
    in_ready_o = 1'b0;
    res_o      = '0;
    req_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          base_d  = base_i;
          e_d     = (op_i == OpInv) ? EW'(InvExp) : EW'(exponent_i[UseBits-1:0]);
          acc_d   = ValueBits'(1);
          state_d = S_HI;
        end
      end
      S_HI: begin
        // upper base bits: base[62:30] mod p
        req_o.start = 1'b1;
        req_o.a     = 32'(base_q[62:60]);
        req_o.b     = HiScale;
        req_o.c     = base_q[59:30];
        kind_d      = K_HI;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (rsp_i.done) begin
          case (kind_q)
            K_HI: begin
              req_o.start = 1'b1;
              req_o.a     = {2'b0, rsp_i.value};
              req_o.b     = {2'b0, Fold30};
              req_o.c     = base_q[29:0];
              kind_d      = K_BASE;
            end
            K_BASE: begin
              sq_d    = rsp_i.value;
              state_d = S_STEP;
            end
            K_ACC: begin
              acc_d       = rsp_i.value;
              req_o.start = 1'b1;
              req_o.a     = {2'b0, sq_q};
              req_o.b     = {2'b0, sq_q};
              kind_d      = K_SQ;
            end
            K_SQ: begin
              sq_d    = rsp_i.value;
              e_d     = e_q >> 1;
              state_d = S_STEP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_STEP: begin
        if (e_q == '0) begin
          state_d = S_DONE;
        end else begin
          req_o.start = 1'b1;
          req_o.b     = {2'b0, sq_q};
          if (e_q[0]) begin
            req_o.a = {2'b0, acc_q};
            kind_d  = K_ACC;
          end else begin
            req_o.a = {2'b0, sq_q};
            kind_d  = K_SQ;
          end
          state_d = S_WAIT;
        end
      end
      S_DONE: begin
        if (res_free_i) begin
          res_o.valid = 1'b1;
          res_o.value = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_HI;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
  end

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Base to a power modulo 1000000007 by square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per operation. tdata carries base and exponent,
//   tuser carries the operation (0 = power, 1 = Fermat inverse, exponent p-2).
//   Master channel: one word per operation, the 30-bit residue.
//   The base is first reduced mod p (two passes of the shared multiply-reduce
//   unit), then the exponent is scanned LSB first up to its top set bit.
//   Each pass of the unit runs on its single 32x32 multiplier: product,
//   quotient estimate, q * p subtract, final correction. Each scanned bit
//   takes a square, and a set bit takes a multiply before it; the inverse
//   exponent p-2 is 30 bits long.
//   s_axis_tready_o is high only while no operation is in flight; one
//   operation is worked on at a time.
//   The result sits in an output register; a new word may be accepted while
//   it waits. If the receiver stalls, the next result holds in the
//   sequencer until the register frees.
//   Reset clears the sequencer and the output valid; no word is pending.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
  import modexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = ExpBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // base[62:0], exponent[125:63], zero pad
  input  logic [0:0]   s_axis_tuser_i,  // op[0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o   // value[29:0], zero pad
);

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  res_t    res;

  logic                 out_valid_q, out_valid_d;
  logic [ValueBits-1:0] out_value_q, out_value_d;
  logic                 res_free;

  assign res_free = !out_valid_q || m_axis_tready_i;

  modexp_seq #(
    .EXP_BITS(EXP_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tuser_i[0]),
    .base_i     (s_axis_tdata_i[62:0]),
    .exponent_i (s_axis_tdata_i[125:63]),
    .res_free_i (res_free),
    .res_o      (res),
    .req_o      (mm_req),
    .rsp_i      (mm_rsp)
  );

  modexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_value_d = res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b0, out_value_q};

  a_no_rsp_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !mm_rsp.done)
    else $error("multiply-reduce response while sequencer idle");

  a_value_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_value_q < PrimeMod))
    else $error("output value not reduced");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwrote pending output word");

  a_no_start_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_req.start |-> !s_axis_tready_o)
    else $error("multiply-reduce start while idle");

endmodule
